/* hdl/llv_pkg.sv */
package llv_pkg;

  localparam int ATOM_SLOTS = 1024;
  localparam int FRAC_BITS  = 24;
  localparam int Q_W        = 40;
  localparam int SLOT_W     = 10;
  localparam int ADDR_W     = $clog2(ATOM_SLOTS);
  localparam int CFG_IDX_W  = 3;
  localparam int REQ_W      = 2;

  typedef logic signed [Q_W-1:0]   q_t;
  typedef logic signed [Q_W+1:0]   qw_t;
  typedef logic [Q_W-2:0]          ucfg_t;

  typedef struct packed {
    logic sat;
    q_t   val;
  } qres_t;

  localparam logic [REQ_W-1:0] REQ_FORCE      = 2'd0;
  localparam logic [REQ_W-1:0] REQ_KICK_DRIFT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FINAL_KICK = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WALL_MODE,
    REG_K_CONFINE,
    REG_CHEM_POTENTIAL,
    REG_FRICTION,
    REG_NOISE_SCALE,
    REG_KICK_GAIN,
    REG_DRIFT_STEP,
    REG_HALF_MASS
  } reg_idx_t;

  // K_NONE: outside group or unknown request, result is all zero
  typedef enum logic [2:0] {
    K_NONE,
    K_DW,
    K_WALL,
    K_KICK1,
    K_KICK2
  } kind_t;

  localparam q_t  Q_MAX = q_t'({1'b0, {(Q_W-1){1'b1}}});
  localparam q_t  Q_MIN = q_t'({1'b1, {(Q_W-1){1'b0}}});
  localparam qw_t ONE_W = qw_t'({{(Q_W+1){1'b0}}, 1'b1} << FRAC_BITS);

  function automatic qw_t wq(input q_t a);
    return (Q_W+2)'(a);
  endfunction

  function automatic q_t ucfg(input ucfg_t u);
    return q_t'({1'b0, u});
  endfunction

  function automatic qres_t qclip(input qw_t x);
    qres_t r;
    r.sat = 1'b0;
    r.val = x[Q_W-1:0];
    if (x > wq(Q_MAX)) begin
      r.sat = 1'b1;
      r.val = Q_MAX;
    end else if (x < wq(Q_MIN)) begin
      r.sat = 1'b1;
      r.val = Q_MIN;
    end
    return r;
  endfunction

  function automatic qres_t qadd(input q_t a, input q_t b);
    return qclip(wq(a) + wq(b));
  endfunction

  function automatic qres_t qsub(input q_t a, input q_t b);
    return qclip(wq(a) - wq(b));
  endfunction

  function automatic qres_t qneg2(input q_t a);
    return qclip(-(wq(a) <<< 1));
  endfunction

endpackage

/* hdl/lambda_langevin_verlet_step.sv */
// Channel   Ports                                          Transaction when
// request   start, busy, req_type, atom_slot, in_group,    start & !busy
//           lambda_in, energy_slope, noise_sample
// result    done, value_out, energy_term, saturated         done (one cycle)
// config    cfg_we, cfg_index, cfg_data                     cfg_we
//
// One request per cycle while busy is low; results come back in order, each request
// passing through pipeline registers p1 to p9 before the registered result strobe. The
// depth is set by the chain of three dependent pipelined multipliers plus the clipped
// force sum. busy is high after reset while both tables are cleared, and while an
// in-flight request to the same atom slot has not yet written back. The receiver cannot stall.
module lambda_langevin_verlet_step (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [llv_pkg::REQ_W-1:0]     req_type,
  input  logic [llv_pkg::SLOT_W-1:0]    atom_slot,
  input  logic                          in_group,
  input  llv_pkg::q_t                   lambda_in,
  input  llv_pkg::q_t                   energy_slope,
  input  llv_pkg::q_t                   noise_sample,
  output logic                          done,
  output llv_pkg::q_t                   value_out,
  output llv_pkg::q_t                   energy_term,
  output logic                          saturated,
  input  logic                          cfg_we,
  input  logic [llv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  llv_pkg::q_t                   cfg_data
);
  import llv_pkg::*;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    q_t                lam;
    q_t                slope;
    q_t                noise;
    q_t                v;
    q_t                d;
    q_t                otm;
    q_t                x;
    q_t                fconf;
    q_t                fric;
    q_t                nz;
    q_t                acc;
    q_t                en;
    q_t                val;
    logic              sat;
  } pipe_t;

  logic  wall_mode;
  ucfg_t k_confine, friction, noise_scale, kick_gain, drift_step, half_mass;
  q_t    chem_potential;

  logic              clearing;
  logic [ADDR_W-1:0] clr_cnt;

  pipe_t p1, p2, p3, p4, p5, p6, p7, p8, p9;
  pipe_t n1, n2, n4, n6, n8, n9, fin;

  q_t    v_rd, f_rd;
  q_t    a_a, a_b, d_a, d_b, e_a, e_b, f_a, f_b;
  qres_t ra, rb, rc, rd, re, rf;

  logic  hit, accept, in_range;
  kind_t new_kind;

  logic              vel_we, frc_we;
  logic [ADDR_W-1:0] vel_wa, frc_wa;
  q_t                vel_wd, frc_wd;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      wall_mode      <= 1'b0;
      k_confine      <= '0;
      chem_potential <= '0;
      friction       <= '0;
      noise_scale    <= '0;
      kick_gain      <= '0;
      drift_step     <= '0;
      half_mass      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WALL_MODE:      wall_mode      <= cfg_data[0];
        REG_K_CONFINE:      k_confine      <= cfg_data[Q_W-2:0];
        REG_CHEM_POTENTIAL: chem_potential <= cfg_data;
        REG_FRICTION:       friction       <= cfg_data[Q_W-2:0];
        REG_NOISE_SCALE:    noise_scale    <= cfg_data[Q_W-2:0];
        REG_KICK_GAIN:      kick_gain      <= cfg_data[Q_W-2:0];
        REG_DRIFT_STEP:     drift_step     <= cfg_data[Q_W-2:0];
        REG_HALF_MASS:      half_mass      <= cfg_data[Q_W-2:0];
      endcase
    end
  end

  // ---------------- table clear after reset ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == ADDR_W'(ATOM_SLOTS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // ---------------- acceptance and slot interlock ----------------
  function automatic logic slot_hit(input pipe_t p, input logic [SLOT_W-1:0] s);
    return p.valid && (p.kind != K_NONE) && (p.slot == s);
  endfunction

  always_comb begin
    hit = slot_hit(p1, atom_slot) | slot_hit(p2, atom_slot) | slot_hit(p3, atom_slot)
        | slot_hit(p4, atom_slot) | slot_hit(p5, atom_slot) | slot_hit(p6, atom_slot)
        | slot_hit(p7, atom_slot) | slot_hit(p8, atom_slot) | slot_hit(p9, atom_slot);
    busy   = clearing | (start & hit);
    accept = start & ~busy;

    in_range = 32'(atom_slot) < ATOM_SLOTS;
    new_kind = K_NONE;
    if (in_group && in_range) begin
      unique case (req_type)
        REQ_FORCE:      new_kind = wall_mode ? K_WALL : K_DW;
        REQ_KICK_DRIFT: new_kind = K_KICK1;
        REQ_FINAL_KICK: new_kind = K_KICK2;
        default:        new_kind = K_NONE;
      endcase
    end

    n1       = '0;
    n1.valid = accept;
    n1.kind  = new_kind;
    n1.slot  = atom_slot;
    n1.lam   = lambda_in;
    n1.slope = energy_slope;
    n1.noise = noise_sample;
  end

  // ---------------- state tables ----------------
  llv_ram u_vel_ram (
    .clk   (clk),
    .we    (vel_we),
    .waddr (vel_wa),
    .wdata (vel_wd),
    .raddr (atom_slot[ADDR_W-1:0]),
    .rdata (v_rd)
  );

  llv_ram u_frc_ram (
    .clk   (clk),
    .we    (frc_we),
    .waddr (frc_wa),
    .wdata (frc_wd),
    .raddr (atom_slot[ADDR_W-1:0]),
    .rdata (f_rd)
  );

  // ---------------- multipliers ----------------
  llv_qmul u_mul_a (.clk(clk), .a(a_a), .b(a_b), .res(ra));
  llv_qmul u_mul_b (.clk(clk), .a(ucfg(friction)), .b(v_rd), .res(rb));
  llv_qmul u_mul_c (.clk(clk), .a(ucfg(noise_scale)), .b(p1.noise), .res(rc));
  llv_qmul u_mul_d (.clk(clk), .a(d_a), .b(d_b), .res(rd));
  llv_qmul u_mul_e (.clk(clk), .a(e_a), .b(e_b), .res(re));
  llv_qmul u_mul_f (.clk(clk), .a(f_a), .b(f_b), .res(rf));

  // stage 1: table data arrives; first product launched
  always_comb begin
    qres_t om, two, otm, fneg;
    qw_t   lm1;
    q_t    dlt;
    n2   = p1;
    a_a  = '0;
    a_b  = '0;
    om   = qclip(ONE_W - wq(p1.lam));
    two  = qadd(p1.lam, p1.lam);
    otm  = qclip(ONE_W - wq(two.val));
    fneg = qclip(-wq(p1.slope));
    lm1  = wq(p1.lam) - ONE_W;
    if (p1.lam < 0) begin
      dlt = p1.lam;
    end else if (wq(p1.lam) > ONE_W) begin
      dlt = lm1[Q_W-1:0];
    end else begin
      dlt = '0;
    end
    n2.v   = v_rd;
    n2.d   = dlt;
    n2.otm = otm.val;
    n2.acc = fneg.val;
    unique case (p1.kind)
      K_DW: begin
        a_a    = p1.lam;
        a_b    = om.val;
        n2.sat = p1.sat | fneg.sat | om.sat | two.sat | otm.sat;
      end
      K_WALL: begin
        a_a    = ucfg(k_confine);
        a_b    = dlt;
        n2.sat = p1.sat | fneg.sat;
      end
      K_KICK1, K_KICK2: begin
        a_a = ucfg(kick_gain);
        a_b = f_rd;
      end
      default: ;
    endcase
  end

  // stage 3: first products back; second product launched
  always_comb begin
    qres_t vn, t2;
    n4      = p3;
    d_a     = '0;
    d_b     = '0;
    vn      = qadd(p3.v, ra.val);
    t2      = qneg2(ra.val);
    n4.fric = rb.val;
    n4.nz   = rc.val;
    unique case (p3.kind)
      K_DW: begin
        n4.x   = ra.val;
        d_a    = ucfg(k_confine);
        d_b    = ra.val;
        n4.sat = p3.sat | ra.sat | rb.sat | rc.sat;
      end
      K_WALL: begin
        d_a      = ra.val;
        d_b      = p3.d;
        n4.fconf = t2.val;
        n4.sat   = p3.sat | ra.sat | rb.sat | rc.sat | t2.sat;
      end
      K_KICK1: begin
        n4.x   = vn.val;
        d_a    = ucfg(drift_step);
        d_b    = vn.val;
        n4.sat = p3.sat | ra.sat | vn.sat;
      end
      K_KICK2: begin
        n4.x   = vn.val;
        d_a    = ucfg(half_mass);
        d_b    = vn.val;
        n4.sat = p3.sat | ra.sat | vn.sat;
      end
      default: ;
    endcase
  end

  // stage 5: second product back; third products launched
  always_comb begin
    qres_t lnew;
    n6   = p5;
    e_a  = '0;
    e_b  = '0;
    f_a  = '0;
    f_b  = '0;
    lnew = qadd(p5.lam, rd.val);
    unique case (p5.kind)
      K_DW: begin
        e_a    = rd.val;
        e_b    = p5.x;
        f_a    = rd.val;
        f_b    = p5.otm;
        n6.sat = p5.sat | rd.sat;
      end
      K_WALL: begin
        n6.en  = rd.val;
        n6.sat = p5.sat | rd.sat;
      end
      K_KICK1: begin
        n6.val = lnew.val;
        n6.sat = p5.sat | rd.sat | lnew.sat;
      end
      K_KICK2: begin
        e_a    = rd.val;
        e_b    = p5.x;
        n6.val = p5.x;
        n6.sat = p5.sat | rd.sat;
      end
      default: ;
    endcase
  end

  // stage 7: energies done; force sum starts (clipped in model order)
  always_comb begin
    qres_t fc, f2;
    q_t    fsel;
    n8   = p7;
    fc   = qneg2(rf.val);
    fsel = (p7.kind == K_DW) ? fc.val : p7.fconf;
    f2   = qadd(p7.acc, fsel);
    unique case (p7.kind)
      K_DW: begin
        n8.en  = re.val;
        n8.acc = f2.val;
        n8.sat = p7.sat | re.sat | rf.sat | fc.sat | f2.sat;
      end
      K_WALL: begin
        n8.acc = f2.val;
        n8.sat = p7.sat | f2.sat;
      end
      K_KICK2: begin
        n8.en  = re.val;
        n8.sat = p7.sat | re.sat;
      end
      default: ;
    endcase
  end

  // stage 8: chemical potential, then friction
  always_comb begin
    qres_t f3, f4;
    n9 = p8;
    f3 = qadd(p8.acc, chem_potential);
    f4 = qsub(f3.val, p8.fric);
    if (p8.kind == K_DW || p8.kind == K_WALL) begin
      n9.acc = f4.val;
      n9.sat = p8.sat | f3.sat | f4.sat;
    end
  end

  // stage 9: noise; write back and result
  always_comb begin
    qres_t f5;
    fin = p9;
    f5  = qadd(p9.acc, p9.nz);
    if (p9.kind == K_DW || p9.kind == K_WALL) begin
      fin.acc = f5.val;
      fin.val = f5.val;
      fin.sat = p9.sat | f5.sat;
    end
  end

  always_comb begin
    vel_we = clearing | (p9.valid & (p9.kind == K_KICK1 || p9.kind == K_KICK2));
    frc_we = clearing | (p9.valid & (p9.kind == K_DW || p9.kind == K_WALL));
    vel_wa = clearing ? clr_cnt : p9.slot[ADDR_W-1:0];
    frc_wa = vel_wa;
    vel_wd = clearing ? '0 : p9.x;
    frc_wd = clearing ? '0 : fin.acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1   <= '0;
      p2   <= '0;
      p3   <= '0;
      p4   <= '0;
      p5   <= '0;
      p6   <= '0;
      p7   <= '0;
      p8   <= '0;
      p9   <= '0;
      done <= 1'b0;
    end else begin
      p1   <= n1;
      p2   <= n2;
      p3   <= p2;
      p4   <= n4;
      p5   <= p4;
      p6   <= n6;
      p7   <= p6;
      p8   <= n8;
      p9   <= n9;
      done <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    value_out   <= fin.val;
    energy_term <= fin.en;
    saturated   <= fin.sat;
  end

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##10 done)
    else $error("accepted transaction did not complete after 10 cycles");

  a_no_slot_overlap: assert property (@(posedge clk) disable iff (rst)
    (p1.valid && p1.kind != K_NONE && p9.valid && p9.kind != K_NONE)
      |-> (p1.slot != p9.slot))
    else $error("two in-flight transactions share an atom slot");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!done && !p9.valid))
    else $error("pipeline active during table clear");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (fin.valid && fin.kind == K_NONE) |=> (value_out == '0 && energy_term == '0
      && !saturated))
    else $error("pass-through transaction gave a nonzero result");
`endif

endmodule

/* hdl/llv_qmul.sv */
module llv_qmul (
  input  logic          clk,
  input  llv_pkg::q_t   a,
  input  llv_pkg::q_t   b,
  output llv_pkg::qres_t res
);
  import llv_pkg::*;

  localparam int H  = Q_W / 2;
  localparam int PW = 2 * Q_W;

  logic [Q_W-1:0] ua, ub;
  logic           neg;
  logic [2*H-1:0] pll, plh, phl, phh;
  logic [PW-1:0]  prod, mag, lim;
  logic [Q_W-1:0] mq;
  qres_t          res_next;

  always_comb begin
    ua = a[Q_W-1] ? -a : a;
    ub = b[Q_W-1] ? -b : b;
  end

  // stage 1: four partial products of the magnitudes
  always_ff @(posedge clk) begin
    neg <= a[Q_W-1] ^ b[Q_W-1];
    pll <= (2*H)'(ua[H-1:0]) * (2*H)'(ub[H-1:0]);
    plh <= (2*H)'(ua[H-1:0]) * (2*H)'(ub[Q_W-1:H]);
    phl <= (2*H)'(ua[Q_W-1:H]) * (2*H)'(ub[H-1:0]);
    phh <= (2*H)'(ua[Q_W-1:H]) * (2*H)'(ub[Q_W-1:H]);
  end

  // stage 2: combine, round half away from zero, clip, restore sign
  always_comb begin
    prod = {phh, pll} + (PW'(plh) << H) + (PW'(phl) << H)
         + (PW'(1) << (FRAC_BITS - 1));
    mag  = prod >> FRAC_BITS;
    lim  = neg ? (PW'(1) << (Q_W - 1)) : ((PW'(1) << (Q_W - 1)) - PW'(1));
    res_next.sat = 1'b0;
    if (mag > lim) begin
      res_next.sat = 1'b1;
      mq = lim[Q_W-1:0];
    end else begin
      mq = mag[Q_W-1:0];
    end
    res_next.val = neg ? -mq : mq;
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

/* hdl/llv_ram.sv */
module llv_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [llv_pkg::ADDR_W-1:0] waddr,
  input  llv_pkg::q_t                wdata,
  input  logic [llv_pkg::ADDR_W-1:0] raddr,
  output llv_pkg::q_t                rdata
);
  import llv_pkg::*;

  q_t mem [ATOM_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* tb/sv/tb_lambda_langevin_verlet_step.sv */
module tb_lambda_langevin_verlet_step;
  timeunit 1ns;
  timeprecision 1ps;
  import llv_pkg::*;

  localparam longint LIM_HI = 64'sh7F_FFFF_FFFF;
  localparam longint LIM_LO = -64'sh80_0000_0000;
  localparam longint ONE_Q  = 64'sd1 << FRAC_BITS;
  localparam int WATCHDOG   = 20000;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [REQ_W-1:0] req_type;
  logic [SLOT_W-1:0] atom_slot;
  logic in_group;
  q_t lambda_in, energy_slope, noise_sample;
  logic done;
  q_t value_out, energy_term;
  logic saturated;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  q_t cfg_data;

  lambda_langevin_verlet_step i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    q_t val;
    q_t en;
    logic sat;
  } step_res_t;

  typedef struct {
    logic [REQ_W-1:0] req;
    logic [SLOT_W-1:0] slot;
    logic grp;
    q_t lam;
    q_t slope;
    q_t noise;
    bit typed;
    step_res_t res;
  } stim_row_t;

  step_res_t step_q[$];
  longint vel_mdl[ATOM_SLOTS];
  longint frc_mdl[ATOM_SLOTS];
  longint cfg_mdl[8];
  bit clip_flag;
  int errors = 0;
  int n_req = 0;
  int n_res = 0;
  int idle_cycles = 0;

  function automatic longint sat_clip(longint x);
    if (x > LIM_HI) begin
      clip_flag = 1'b1;
      return LIM_HI;
    end
    if (x < LIM_LO) begin
      clip_flag = 1'b1;
      return LIM_LO;
    end
    return x;
  endfunction

  // exact product, round half away from zero, then clip
  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] ua, ub, mag, lim;
    bit neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 128'(-a) : 128'(a);
    ub = (b < 0) ? 128'(-b) : 128'(b);
    mag = (ua * ub + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    lim = neg ? (128'd1 << 39) : 128'(LIM_HI);
    if (mag > lim) begin
      clip_flag = 1'b1;
      mag = lim;
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic void cfg_apply(reg_idx_t idx, q_t d);
    if (idx == REG_WALL_MODE) cfg_mdl[idx] = longint'(d[0]);
    else if (idx == REG_CHEM_POTENTIAL) cfg_mdl[idx] = longint'(d);
    else cfg_mdl[idx] = longint'({1'b0, d[Q_W-2:0]});
  endfunction

  function automatic step_res_t integrate(logic [REQ_W-1:0] req, logic [SLOT_W-1:0] slot,
                                          logic grp, q_t lam_i, q_t slope_i, q_t noise_i);
    step_res_t r;
    longint lam, fconf, f, t, d, om, otm, s, q, v, val, en;
    lam = longint'(lam_i);
    val = 0;
    en = 0;
    fconf = 0;
    clip_flag = 1'b0;
    if (grp && slot < ATOM_SLOTS && req <= REQ_FINAL_KICK) begin
      if (req == REQ_FORCE) begin
        if (cfg_mdl[REG_WALL_MODE] != 0) begin
          if (lam < 0 || lam > ONE_Q) begin
            d = (lam < 0) ? lam : lam - ONE_Q;
            t = fx_mul(cfg_mdl[REG_K_CONFINE], d);
            fconf = sat_clip(-2 * t);
            en = fx_mul(t, d);
          end
        end else begin
          om = sat_clip(ONE_Q - lam);
          otm = sat_clip(ONE_Q - sat_clip(2 * lam));
          s = fx_mul(lam, om);
          q = fx_mul(cfg_mdl[REG_K_CONFINE], s);
          en = fx_mul(q, s);
          fconf = sat_clip(-2 * fx_mul(q, otm));
        end
        f = sat_clip(-longint'(slope_i));
        f = sat_clip(f + fconf);
        f = sat_clip(f + cfg_mdl[REG_CHEM_POTENTIAL]);
        f = sat_clip(f - fx_mul(cfg_mdl[REG_FRICTION], vel_mdl[slot]));
        f = sat_clip(f + fx_mul(cfg_mdl[REG_NOISE_SCALE], longint'(noise_i)));
        frc_mdl[slot] = f;
        val = f;
      end else begin
        v = sat_clip(vel_mdl[slot] + fx_mul(cfg_mdl[REG_KICK_GAIN], frc_mdl[slot]));
        vel_mdl[slot] = v;
        if (req == REQ_KICK_DRIFT) begin
          val = sat_clip(lam + fx_mul(cfg_mdl[REG_DRIFT_STEP], v));
        end else begin
          val = v;
          en = fx_mul(fx_mul(cfg_mdl[REG_HALF_MASS], v), v);
        end
      end
    end
    r.val = q_t'(val);
    r.en = q_t'(en);
    r.sat = clip_flag;
    return r;
  endfunction

  function automatic q_t rand_q(int mode);
    logic [63:0] w;
    w = {$urandom, $urandom};
    case (mode)
      0: return q_t'(w);
      1: return q_t'($signed(w[27:0]));     // about +-8.0
      2: return q_t'($signed(w[25:0]) + (w[40] ? ONE_Q : 0));
      default: begin
        case (w[1:0])
          2'd0: return Q_MAX;
          2'd1: return Q_MIN;
          2'd2: return q_t'(ONE_Q);
          default: return '0;
        endcase
      end
    endcase
  endfunction

  task automatic send(stim_row_t row);
    step_res_t r;
    start <= 1'b1;
    req_type <= row.req;
    atom_slot <= row.slot;
    in_group <= row.grp;
    lambda_in <= row.lam;
    energy_slope <= row.slope;
    noise_sample <= row.noise;
    do @(posedge clk); while (busy);
    r = integrate(row.req, row.slot, row.grp, row.lam, row.slope, row.noise);
    step_q.push_back(row.typed ? row.res : r);
    n_req++;
  endtask

  task automatic pause_random();
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (step_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_cfg(reg_idx_t idx, q_t d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_apply(idx, d);
  endtask

  task automatic random_item(int slot_pool, int qmode);
    stim_row_t row;
    int k;
    row.typed = 1'b0;
    row.grp = 1'b1;
    row.slot = SLOT_W'($urandom_range(0, slot_pool));
    row.lam = rand_q(qmode);
    row.slope = rand_q(qmode);
    row.noise = rand_q(qmode);
    if ($urandom_range(0, 9) < 7) begin
      // well-formed step on one atom: force, kick-drift, final kick
      for (k = 0; k < 3; k++) begin
        row.req = k[REQ_W-1:0];
        send(row);
        pause_random();
        row.lam = rand_q(qmode);
        row.slope = rand_q(qmode);
        row.noise = rand_q(qmode);
      end
    end else begin
      row.req = REQ_W'($urandom_range(0, 3));
      row.grp = $urandom_range(0, 4) != 0;
      row.slot = SLOT_W'($urandom);
      send(row);
      pause_random();
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      n_res++;
      if (step_q.size() == 0) begin
        $error("result with no pending transaction: value_out=%h", value_out);
        errors++;
      end else begin
        step_res_t e;
        e = step_q.pop_front();
        if (value_out !== e.val) begin
          $error("value_out: expected %h, got %h", e.val, value_out);
          errors++;
        end
        if (energy_term !== e.en) begin
          $error("energy_term: expected %h, got %h", e.en, energy_term);
          errors++;
        end
        if (saturated !== e.sat) begin
          $error("saturated: expected %b, got %b", e.sat, saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG);
      $display("*** FAILED ***");
      $finish;
    end
  end

  stim_row_t dir_tbl[] = '{
    '{REQ_FORCE, 10'd0, 1'b1, '0, '0, '0, 1'b1, '{'0, '0, 1'b0}},
    '{REQ_KICK_DRIFT, 10'd0, 1'b1, '0, '0, '0, 1'b1, '{'0, '0, 1'b0}},
    '{REQ_FINAL_KICK, 10'd0, 1'b1, '0, '0, '0, 1'b1, '{'0, '0, 1'b0}},
    '{REQ_FORCE, 10'd1023, 1'b0, Q_MAX, Q_MIN, Q_MAX, 1'b1, '{'0, '0, 1'b0}},
    '{REQ_FINAL_KICK, 10'd5, 1'b0, Q_MIN, Q_MAX, Q_MIN, 1'b1, '{'0, '0, 1'b0}},
    '{2'd3, 10'd7, 1'b1, Q_MAX, Q_MAX, Q_MAX, 1'b1, '{'0, '0, 1'b0}},
    '{2'd3, 10'd1023, 1'b1, Q_MIN, Q_MIN, Q_MIN, 1'b1, '{'0, '0, 1'b0}},
    '{REQ_FORCE, 10'd2, 1'b1, '0, Q_MIN, '0, 1'b1, '{Q_MAX, '0, 1'b1}},
    '{REQ_FORCE, 10'd3, 1'b1, '0, Q_MAX, '0, 1'b1, '{-Q_MAX, '0, 1'b0}},
    '{REQ_FORCE, 10'd4, 1'b1, Q_MIN, '0, Q_MAX, 1'b0, '{'0, '0, 1'b0}},
    '{REQ_FORCE, 10'd1023, 1'b1, Q_MAX, 40'sh12345678, Q_MIN, 1'b0, '{'0, '0, 1'b0}},
    '{REQ_KICK_DRIFT, 10'd2, 1'b1, Q_MAX, '0, '0, 1'b0, '{'0, '0, 1'b0}},
    '{REQ_FINAL_KICK, 10'd2, 1'b1, Q_MIN, '0, '0, 1'b0, '{'0, '0, 1'b0}},
    '{REQ_KICK_DRIFT, 10'd1023, 1'b1, Q_MIN, '0, '0, 1'b0, '{'0, '0, 1'b0}},
    '{REQ_FINAL_KICK, 10'd1023, 1'b1, '0, '0, '0, 1'b0, '{'0, '0, 1'b0}}
  };

  initial begin
    int ph, i, j;
    q_t regv[8];
    rst <= 1'b1;
    start <= 1'b0;
    req_type <= '0;
    atom_slot <= '0;
    in_group <= 1'b0;
    lambda_in <= '0;
    energy_slope <= '0;
    noise_sample <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    foreach (cfg_mdl[k]) cfg_mdl[k] = 0;
    foreach (vel_mdl[k]) begin
      vel_mdl[k] = 0;
      frc_mdl[k] = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tbl[k]) begin
      send(dir_tbl[k]);
      pause_random();
    end

    // phase 0: all registers at maximum, then mixes of small, full-range and zero settings
    for (ph = 0; ph < 6; ph++) begin
      drain();
      for (i = 0; i < 8; i++) begin
        case (ph)
          0: regv[i] = (i == REG_CHEM_POTENTIAL) ? Q_MIN : Q_MAX;
          1: regv[i] = '0;
          2, 3: regv[i] = q_t'($urandom_range(0, 1 << 26));
          4: regv[i] = rand_q(0);
          default: regv[i] = q_t'($urandom_range(0, 1 << 23));
        endcase
        if (i == REG_WALL_MODE) regv[i] = (ph == 0) ? q_t'(1) : q_t'(ph & 1);
        if (i == REG_CHEM_POTENTIAL && ph > 1) regv[i] = rand_q(1);
        write_cfg(reg_idx_t'(i), regv[i]);
      end
      write_cfg(REG_CHEM_POTENTIAL, (ph == 0) ? Q_MAX : regv[REG_CHEM_POTENTIAL]);
      cfg_we <= 1'b0;
      for (j = 0; j < 30; j++)
        random_item((ph % 2 == 0) ? 7 : 1023, (j % 5 == 0) ? 0 : (j % 3 == 0 ? 3 : 2));
    end

    drain();
    if (step_q.size() != 0) begin
      $error("%0d expected results never arrived", step_q.size());
      errors++;
    end
    $display("Ran %0d requests over 6 register settings, %0d results checked.", n_req, n_res);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
